// File: design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions used in the design folder.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property, muted while reset is asserted (active-low reset).
`define RIOT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Checked property that also holds during reset.
`define RIOT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/riot_pkg.sv
// ---------------------------------------------------------------------------
// riot_pkg
// Types and constants shared by the RAM, I/O and timer block.
// ---------------------------------------------------------------------------
package riot_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_NONE  = 2'd3
  } riot_op_e;

  // I/O register select, address bits [2:0] after the 0x287 mask
  typedef enum logic [2:0] {
    REG_PORTA  = 3'd0,
    REG_DDRA   = 3'd1,
    REG_PORTB  = 3'd2,
    REG_DDRB   = 3'd3,
    REG_TIM1T  = 3'd4,
    REG_TIM8T  = 3'd5,
    REG_TIM64T = 3'd6,
    REG_T1024T = 3'd7
  } riot_reg_e;

  localparam int unsigned IoSelBit  = 9;  // address bit picking I/O over RAM
  localparam int unsigned IoOkBit   = 7;  // must be set for a decoded I/O register
  localparam int unsigned RamAddrW  = 7;  // address bits feeding the RAM index
  localparam int unsigned PreW      = 11;

  localparam logic [7:0]      PortARst = 8'hFF;
  localparam logic [7:0]      PortBRst = 8'h0B;
  localparam logic [7:0]      RamRst   = 8'hFF;
  localparam logic [PreW-1:0] Div1     = 11'd1;
  localparam logic [PreW-1:0] Div8     = 11'd8;
  localparam logic [PreW-1:0] Div64    = 11'd64;
  localparam logic [PreW-1:0] Div1024  = 11'd1024;

  // Work handed from the stage register to the I/O unit
  typedef struct packed {
    logic      fire;    // stage item executes this cycle
    riot_op_e  op;
    logic      sel_ok;  // address bit 7 set
    riot_reg_e sel;
    logic [7:0] wdata;
    logic [7:0] pins_a;
    logic [7:0] pins_b;
  } riot_io_req_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       bad;
  } riot_io_rsp_t;

endpackage

// File: design/riot_ram_io_timer.sv
// ---------------------------------------------------------------------------
// riot_ram_io_timer
// RAM, I/O port and interval timer block driven by tick, read and write beats.
// ---------------------------------------------------------------------------
// Throughput is one beat per clock while out_stall_i is low; every input
// beat yields exactly one result beat. The pipe has two registers: a stage
// register (which also captures the scratch RAM read, addressed straight from
// the input port) and the result register. The stage item executes as it moves
// into the result register, so a write in the stage is visible to the very
// next beat: RAM by a write-to-read bypass, I/O and timer by plain register
// update. in_stall_o rises only when the stage is full and the result register
// is held by out_stall_i. No clearing pass after reset: each RAM byte has a
// valid bit and reads 0xFF until first written.
`include "assert_macros.svh"

module riot_ram_io_timer #(
  parameter int unsigned RAM_BYTES = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  riot_pkg::riot_op_e  op_i,
  input  logic [15:0]         address_i,
  input  logic [7:0]          write_data_i,
  input  logic [7:0]          port_a_pins_i,
  input  logic [7:0]          port_b_pins_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          read_data_o,
  output logic                bad_address_o
);
  import riot_pkg::*;

  localparam int unsigned IdxW     = $clog2(RAM_BYTES);
  localparam int unsigned ModSteps = 127 / RAM_BYTES;

  // (address & 0x7F) % RAM_BYTES by repeated compare and subtract
  function automatic logic [IdxW-1:0] ram_index(input logic [RamAddrW-1:0] a);
    logic [RamAddrW:0] r;
    r = {1'b0, a};
    for (int k = 0; k < ModSteps; k++) begin
      if (r >= (RamAddrW+1)'(RAM_BYTES)) begin
        r = r - (RamAddrW+1)'(RAM_BYTES);
      end
    end
    return r[IdxW-1:0];
  endfunction

  // handshake
  logic accept, advance;

  // stage register
  logic            s1_vld_q;
  riot_op_e        op_q;
  logic            is_io_q;
  logic            sel_ok_q;
  riot_reg_e       sel_q;
  logic [IdxW-1:0] idx_q;
  logic [7:0]      wdata_q, pins_a_q, pins_b_q;

  // result register
  logic       out_vld_q;
  logic [7:0] rdata_q, rdata_d;
  logic       bad_q, bad_d;

  logic [IdxW-1:0] rd_idx;
  logic [7:0]      ram_rd;
  logic            ram_we;
  riot_io_req_t    io_req;
  riot_io_rsp_t    io_rsp;

  assign advance    = s1_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = s1_vld_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  assign rd_idx = ram_index(address_i[RamAddrW-1:0]);
  assign ram_we = advance && (op_q == OP_WRITE) && !is_io_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_vld_q <= 1'b1;
      end else if (advance) begin
        s1_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= op_i;
      is_io_q  <= address_i[IoSelBit];
      sel_ok_q <= address_i[IoOkBit];
      sel_q    <= riot_reg_e'(address_i[2:0]);
      idx_q    <= rd_idx;
      wdata_q  <= write_data_i;
      pins_a_q <= port_a_pins_i;
      pins_b_q <= port_b_pins_i;
    end
    if (advance) begin
      rdata_q <= rdata_d;
      bad_q   <= bad_d;
    end
  end

  riot_ram #(
    .Depth (RAM_BYTES),
    .IdxW  (IdxW)
  ) u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_idx_i  (rd_idx),
    .wr_en_i   (ram_we),
    .wr_idx_i  (idx_q),
    .wr_data_i (wdata_q),
    .rd_data_o (ram_rd)
  );

  // ticks always reach the I/O unit; reads and writes only on I/O addresses
  always_comb begin
    io_req.fire   = advance && ((op_q == OP_TICK) || is_io_q);
    io_req.op     = op_q;
    io_req.sel_ok = sel_ok_q;
    io_req.sel    = sel_q;
    io_req.wdata  = wdata_q;
    io_req.pins_a = pins_a_q;
    io_req.pins_b = pins_b_q;
  end

  riot_io u_io (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (io_req),
    .rsp_o  (io_rsp)
  );

  always_comb begin
    rdata_d = 8'h00;
    bad_d   = 1'b0;
    case (op_q)
      OP_READ: begin
        rdata_d = is_io_q ? io_rsp.rdata : ram_rd;
        bad_d   = is_io_q && io_rsp.bad;
      end
      OP_WRITE: bad_d = is_io_q && io_rsp.bad;
      default: ;
    endcase
  end

  assign out_valid_o   = out_vld_q;
  assign read_data_o   = rdata_q;
  assign bad_address_o = bad_q;

  `RIOT_ASSERT(a_stall_needs_stage, clk_i, rst_ni, in_stall_o |-> s1_vld_q && out_vld_q, "stall without a full pipe")
  `RIOT_ASSERT(a_accept_fills, clk_i, rst_ni, accept |=> s1_vld_q, "accepted beat lost from stage")
  `RIOT_ASSERT(a_advance_shows, clk_i, rst_ni, advance |=> out_vld_q, "executed beat not presented")
  `RIOT_ASSERT(a_held_stage, clk_i, rst_ni, (s1_vld_q && !advance) |=> s1_vld_q && $stable(idx_q), "held stage item changed")
  `RIOT_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> !s1_vld_q && !out_vld_q, "pipe not empty after reset")

endmodule

// File: design/riot_ram.sv
// ---------------------------------------------------------------------------
// riot_ram
// Scratch RAM with per-byte valid bits and a registered, bypassed read.
// ---------------------------------------------------------------------------
module riot_ram #(
  parameter int unsigned Depth = 128,
  parameter int unsigned IdxW  = 7
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rd_en_i,
  input  logic [IdxW-1:0] rd_idx_i,
  input  logic            wr_en_i,
  input  logic [IdxW-1:0] wr_idx_i,
  input  logic [7:0]      wr_data_i,
  output logic [7:0]      rd_data_o
);
  import riot_pkg::*;

  logic [7:0]       mem [Depth];
  logic [Depth-1:0] vld_q;
  logic [7:0]       raw_q;
  logic             hit_q;
  logic             byp_q;
  logic [7:0]       byp_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      raw_q      <= mem[rd_idx_i];
      byp_data_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      hit_q <= 1'b0;
      byp_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_idx_i] <= 1'b1;
      end
      if (rd_en_i) begin
        hit_q <= vld_q[rd_idx_i];
        byp_q <= wr_en_i && (wr_idx_i == rd_idx_i);
      end
    end
  end

  // same-cycle write wins, never-written bytes read as the reset fill
  assign rd_data_o = byp_q ? byp_data_q : (hit_q ? raw_q : RamRst);

endmodule

// File: design/riot_io.sv
// ---------------------------------------------------------------------------
// riot_io
// Port, direction and interval timer registers with their tick update.
// ---------------------------------------------------------------------------
module riot_io (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  riot_pkg::riot_io_req_t req_i,
  output riot_pkg::riot_io_rsp_t rsp_o
);
  import riot_pkg::*;

  logic [7:0]      pa_q, pa_d, pb_q, pb_d;
  logic [7:0]      ddra_q, ddra_d, ddrb_q, ddrb_d;
  logic [7:0]      tim_q, tim_d;
  logic [PreW-1:0] div_q, div_d;
  logic [PreW-1:0] pre_q, pre_d;
  logic            uf_q, uf_d;
  logic [PreW-1:0] pre_inc;
  logic            is_acc;

  assign pre_inc = pre_q + PreW'(1);
  assign is_acc  = (req_i.op == OP_READ) || (req_i.op == OP_WRITE);

  // read data and bad-address flag
  always_comb begin
    rsp_o.rdata = 8'h00;
    rsp_o.bad   = is_acc && !req_i.sel_ok;
    if (req_i.op == OP_READ && req_i.sel_ok) begin
      case (req_i.sel)
        REG_PORTA:              rsp_o.rdata = pa_q;
        REG_DDRA:               rsp_o.rdata = ddra_q;
        REG_PORTB:              rsp_o.rdata = pb_q;
        REG_DDRB:               rsp_o.rdata = ddrb_q;
        REG_TIM1T, REG_TIM64T:  rsp_o.rdata = tim_q;
        default:                rsp_o.rdata = 8'h00;  // status reads zero
      endcase
    end
  end

  always_comb begin
    pa_d   = pa_q;
    pb_d   = pb_q;
    ddra_d = ddra_q;
    ddrb_d = ddrb_q;
    tim_d  = tim_q;
    div_d  = div_q;
    pre_d  = pre_q;
    uf_d   = uf_q;
    if (req_i.fire) begin
      case (req_i.op)
        OP_TICK: begin
          pre_d = pre_inc;
          if (pre_inc > div_q || uf_q) begin
            pre_d = '0;
            tim_d = tim_q - 8'd1;
            if (tim_q == 8'h00) begin
              uf_d = 1'b1;
            end
          end
          pa_d = req_i.pins_a | (pa_q & ddra_q);
          pb_d = req_i.pins_b | (pb_q & ddrb_q);
        end
        OP_READ: begin
          if (req_i.sel_ok && (req_i.sel == REG_TIM1T || req_i.sel == REG_TIM64T)) begin
            uf_d = 1'b0;
          end
        end
        OP_WRITE: begin
          if (req_i.sel_ok) begin
            case (req_i.sel)
              REG_PORTA: pa_d   = req_i.wdata;
              REG_DDRA:  ddra_d = req_i.wdata;
              REG_PORTB: pb_d   = req_i.wdata;
              REG_DDRB:  ddrb_d = req_i.wdata;
              default: begin
                // timer load: low two select bits pick the prescale
                case (req_i.sel)
                  REG_TIM1T:  div_d = Div1;
                  REG_TIM8T:  div_d = Div8;
                  REG_TIM64T: div_d = Div64;
                  default:    div_d = Div1024;
                endcase
                tim_d = req_i.wdata - 8'd1;
                pre_d = '0;
                uf_d  = 1'b0;
              end
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pa_q   <= PortARst;
      pb_q   <= PortBRst;
      ddra_q <= 8'h00;
      ddrb_q <= 8'h00;
      tim_q  <= 8'h00;
      div_q  <= Div1024;
      pre_q  <= '0;
      uf_q   <= 1'b0;
    end else begin
      pa_q   <= pa_d;
      pb_q   <= pb_d;
      ddra_q <= ddra_d;
      ddrb_q <= ddrb_d;
      tim_q  <= tim_d;
      div_q  <= div_d;
      pre_q  <= pre_d;
      uf_q   <= uf_d;
    end
  end

endmodule

// File: tb/sv/riot_bus_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// riot_bus_checker
// Watches both channels of the RAM, I/O and timer block. It keeps its own copy
// of the RAM, port, direction and timer state, predicts the result of each
// input beat, and compares every result beat in order.
// ---------------------------------------------------------------------------
module riot_bus_checker #(
  parameter int unsigned RAM_BYTES = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  riot_pkg::riot_op_e op_i,
  input  logic [15:0]        address_i,
  input  logic [7:0]         write_data_i,
  input  logic [7:0]         port_a_pins_i,
  input  logic [7:0]         port_b_pins_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [7:0]         read_data_i,
  input  logic               bad_address_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  import riot_pkg::*;

  typedef struct {
    riot_op_e    op;
    logic [15:0] addr;
    logic [7:0]  rdata;
    logic        bad;
  } bus_result_t;

  bus_result_t bus_results_q[$];
  bus_result_t want;

  // mirrored block state
  logic [7:0]      ram_copy [RAM_BYTES];
  logic [7:0]      porta_val, portb_val, ddra_val, ddrb_val;
  logic [7:0]      timer_val;
  logic [PreW-1:0] pre_div, pre_cnt;
  logic            timer_uflow;

  task automatic report_mismatch(input string msg);
    fail_count_o++;
    $display("%0t ns  mismatch: %s", $time, msg);
  endtask

  task automatic reset_state();
    foreach (ram_copy[i]) ram_copy[i] = RamRst;
    porta_val   = PortARst;
    portb_val   = PortBRst;
    ddra_val    = '0;
    ddrb_val    = '0;
    timer_val   = '0;
    pre_div     = Div1024;
    pre_cnt     = '0;
    timer_uflow = 1'b0;
  endtask

  function automatic void load_timer(input logic [PreW-1:0] div, input logic [7:0] val);
    pre_div     = div;
    timer_val   = val - 8'd1;
    pre_cnt     = '0;
    timer_uflow = 1'b0;
  endfunction

  // Advances the mirrored state by one beat and returns its result.
  function automatic bus_result_t bus_beat_result(input riot_op_e op,
                                                  input logic [15:0] addr,
                                                  input logic [7:0] wdata,
                                                  input logic [7:0] pins_a,
                                                  input logic [7:0] pins_b);
    bus_result_t res;
    int unsigned idx;
    riot_reg_e   sel;
    res.op    = op;
    res.addr  = addr;
    res.rdata = '0;
    res.bad   = 1'b0;
    idx = int'(addr[RamAddrW-1:0]) % RAM_BYTES;
    sel = riot_reg_e'(addr[2:0]);
    case (op)
      OP_TICK: begin
        pre_cnt = pre_cnt + PreW'(1);
        if (pre_cnt > pre_div || timer_uflow) begin
          pre_cnt   = '0;
          timer_val = timer_val - 8'd1;
          if (timer_val == 8'hFF) timer_uflow = 1'b1;
        end
        porta_val = pins_a | (porta_val & ddra_val);
        portb_val = pins_b | (portb_val & ddrb_val);
      end
      OP_READ: begin
        if (!addr[IoSelBit]) begin
          res.rdata = ram_copy[idx];
        end else if (!addr[IoOkBit]) begin
          res.bad = 1'b1;
        end else begin
          case (sel)
            REG_PORTA: res.rdata = porta_val;
            REG_DDRA:  res.rdata = ddra_val;
            REG_PORTB: res.rdata = portb_val;
            REG_DDRB:  res.rdata = ddrb_val;
            REG_TIM1T, REG_TIM64T: begin
              res.rdata   = timer_val;
              timer_uflow = 1'b0;
            end
            default: res.rdata = '0;  // status reads zero
          endcase
        end
      end
      OP_WRITE: begin
        if (!addr[IoSelBit]) begin
          ram_copy[idx] = wdata;
        end else if (!addr[IoOkBit]) begin
          res.bad = 1'b1;
        end else begin
          case (sel)
            REG_PORTA:  porta_val = wdata;
            REG_DDRA:   ddra_val  = wdata;
            REG_PORTB:  portb_val = wdata;
            REG_DDRB:   ddrb_val  = wdata;
            REG_TIM1T:  load_timer(Div1, wdata);
            REG_TIM8T:  load_timer(Div8, wdata);
            REG_TIM64T: load_timer(Div64, wdata);
            default:    load_timer(Div1024, wdata);
          endcase
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      reset_state();
      bus_results_q.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (bus_results_q.size() == 0) begin
          report_mismatch($sformatf("result beat rd=%02h bad=%0b with nothing pending",
                                    read_data_i, bad_address_i));
        end else begin
          want = bus_results_q.pop_front();
          if (read_data_i !== want.rdata)
            report_mismatch($sformatf("%s @%04h read_data %02h, expected %02h",
                                      want.op.name(), want.addr, read_data_i, want.rdata));
          if (bad_address_i !== want.bad)
            report_mismatch($sformatf("%s @%04h bad_address %0b, expected %0b",
                                      want.op.name(), want.addr, bad_address_i, want.bad));
        end
      end
      if (in_valid_i && !in_stall_i)
        bus_results_q.push_back(bus_beat_result(op_i, address_i, write_data_i,
                                                port_a_pins_i, port_b_pins_i));
      pending_o <= bus_results_q.size();
    end
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Drives tick, read and write beats into the RAM, I/O and timer block under
// several idle and stall patterns; a checker beside the block predicts and
// compares every result beat.
// ---------------------------------------------------------------------------
module testbench;
  import riot_pkg::*;

  localparam int unsigned RamBytes    = 128;
  localparam int          PhaseBeats  = 212;  // random beats per idle phase
  localparam int          DrainCycles = 4;    // pipe is two deep

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  riot_op_e    bus_op      = OP_NONE;
  logic [15:0] bus_addr    = '0;
  logic [7:0]  bus_wdata   = '0;
  logic [7:0]  pins_a      = '0;
  logic [7:0]  pins_b      = '0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  logic [7:0]  read_data;
  logic        bad_address;

  int fail_count;
  int pending;

  // per-phase idle odds, in percent
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  riot_ram_io_timer #(
    .RAM_BYTES(RamBytes)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .op_i         (bus_op),
    .address_i    (bus_addr),
    .write_data_i (bus_wdata),
    .port_a_pins_i(pins_a),
    .port_b_pins_i(pins_b),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .read_data_o  (read_data),
    .bad_address_o(bad_address)
  );

  riot_bus_checker #(
    .RAM_BYTES(RamBytes)
  ) checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .op_i         (bus_op),
    .address_i    (bus_addr),
    .write_data_i (bus_wdata),
    .port_a_pins_i(pins_a),
    .port_b_pins_i(pins_b),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .read_data_i  (read_data),
    .bad_address_i(bad_address),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Result side: stall is redrawn every cycle at the phase's odds.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

  // Address of an I/O register: bits 9 and 7 set, register in bits 2:0.
  function automatic logic [15:0] io_addr(input riot_reg_e r);
    return 16'h0280 | 16'(r);
  endfunction

  // Random byte and address for don't-care fields.
  function automatic logic [7:0] rnd8();
    return 8'($urandom);
  endfunction

  function automatic logic [15:0] rnd16();
    return 16'($urandom);
  endfunction

  // One input beat. Optional idle cycles first (valid low), then valid is
  // held with a steady payload until the block takes it.
  task automatic drive_bus_beat(input riot_op_e op, input logic [15:0] addr,
                                input logic [7:0] wdata, input logic [7:0] pa,
                                input logic [7:0] pb);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    bus_op    <= op;
    bus_addr  <= addr;
    bus_wdata <= wdata;
    pins_a    <= pa;
    pins_b    <= pb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    int          r;
    riot_op_e    op;
    logic [15:0] addr;
    logic [7:0]  wdata;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < 4; ph++) begin
      // phases: free running, sparse sender, heavy back-pressure, light both
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase

      if (ph == 0) begin
        // RAM reset value, write at the top byte, read back through high
        // address bits that the decoder ignores
        drive_bus_beat(OP_READ,  16'h0000, rnd8(), rnd8(), rnd8());
        drive_bus_beat(OP_WRITE, 16'h007F, 8'h00, rnd8(), rnd8());
        drive_bus_beat(OP_READ,  16'hFD7F, rnd8(), rnd8(), rnd8());
        // port reset values
        drive_bus_beat(OP_READ,  io_addr(REG_PORTA), rnd8(), rnd8(), rnd8());
        drive_bus_beat(OP_READ,  io_addr(REG_PORTB), rnd8(), rnd8(), rnd8());
        // direction A via a fully set address, then port outputs
        drive_bus_beat(OP_WRITE, 16'hFFF9, 8'hF0, rnd8(), rnd8());
        drive_bus_beat(OP_WRITE, io_addr(REG_PORTA), 8'hAA, rnd8(), rnd8());
        drive_bus_beat(OP_WRITE, io_addr(REG_DDRB), 8'h0F, rnd8(), rnd8());
        // tick merges pins with the driven output bits
        drive_bus_beat(OP_TICK,  rnd16(), rnd8(), 8'h00, 8'hF0);
        drive_bus_beat(OP_READ,  io_addr(REG_PORTA), rnd8(), rnd8(), rnd8());
        drive_bus_beat(OP_READ,  io_addr(REG_DDRA), rnd8(), rnd8(), rnd8());
        drive_bus_beat(OP_READ,  io_addr(REG_DDRB), rnd8(), rnd8(), rnd8());
        // divide-by-one timer from 1: underflows on the second tick, then
        // keeps counting every tick until the timer is read
        drive_bus_beat(OP_WRITE, io_addr(REG_TIM1T), 8'h01, rnd8(), rnd8());
        drive_bus_beat(OP_TICK,  rnd16(), rnd8(), 8'hFF, 8'h00);
        drive_bus_beat(OP_TICK,  rnd16(), rnd8(), rnd8(), rnd8());
        drive_bus_beat(OP_TICK,  rnd16(), rnd8(), rnd8(), rnd8());
        drive_bus_beat(OP_READ,  io_addr(REG_TIM1T), rnd8(), rnd8(), rnd8());
        drive_bus_beat(OP_READ,  io_addr(REG_TIM8T), rnd8(), rnd8(), rnd8());
        // remaining timer loads, zero and all-ones data
        drive_bus_beat(OP_WRITE, io_addr(REG_TIM8T), 8'h00, rnd8(), rnd8());
        drive_bus_beat(OP_WRITE, io_addr(REG_TIM64T), 8'hFF, rnd8(), rnd8());
        drive_bus_beat(OP_WRITE, io_addr(REG_T1024T), 8'h80, rnd8(), rnd8());
        // unhandled I/O (bit 7 clear) on read and write, unused op, status
        drive_bus_beat(OP_READ,  16'h0200, rnd8(), rnd8(), rnd8());
        drive_bus_beat(OP_WRITE, 16'h0207, 8'h55, rnd8(), rnd8());
        drive_bus_beat(OP_NONE,  16'hFFFF, 8'hFF, rnd8(), rnd8());
        drive_bus_beat(OP_READ,  io_addr(REG_T1024T), rnd8(), rnd8(), rnd8());
      end

      repeat (PhaseBeats) begin
        r  = $urandom_range(99);
        op = (r < 40) ? OP_TICK : (r < 70) ? OP_READ : (r < 95) ? OP_WRITE : OP_NONE;
        addr  = 16'($urandom);
        wdata = 8'($urandom);
        if ($urandom_range(1)) begin
          addr[IoSelBit] = 1'b0;
          // crowd half the RAM traffic into a few bytes for read-after-write
          if ($urandom_range(1)) addr[RamAddrW-1:0] = 7'($urandom_range(7));
        end else begin
          addr[IoSelBit] = 1'b1;
          addr[IoOkBit]  = ($urandom_range(7) != 0);
          // short timer loads so underflow shows up often
          if (addr[2] && $urandom_range(1)) wdata = 8'($urandom_range(3));
        end
        drive_bus_beat(op, addr, wdata, rnd8(), rnd8());
      end

      // hold off until every result of this phase is back
      in_valid <= 1'b0;
      do @(posedge clk); while (pending != 0);
    end

    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
